// ===== hw/rtl/lgts_pkg.sv =====
// Shared types and constants for the LDA Gibbs topic sampler.
`timescale 1ns / 1ps
`default_nettype none
package lgts_pkg;

  localparam int DOC_W   = 14;
  localparam int WORD_W  = 11;
  localparam int TOPIC_W = 4;
  localparam int DEN_W   = 49;

  localparam logic [1:0] REG_ALPHA    = 2'd0;
  localparam logic [1:0] REG_BETA     = 2'd1;
  localparam logic [1:0] REG_BETA_SUM = 2'd2;
  localparam logic [1:0] REG_ACTIVE   = 2'd3;

  localparam logic [31:0] ALPHA_RST    = 32'd204800;
  localparam logic [31:0] BETA_RST     = 32'd6980;
  localparam logic [31:0] BETA_SUM_RST = 32'd13107200;
  localparam logic [4:0]  ACTIVE_RST   = 5'd16;

  typedef enum logic [14:0] {
    S_CLEAR = 15'b000000000000001,
    S_IDLE  = 15'b000000000000010,
    S_READ  = 15'b000000000000100,
    S_LOAD  = 15'b000000000001000,
    S_DEC   = 15'b000000000010000,
    S_MUL   = 15'b000000000100000,
    S_DST   = 15'b000000001000000,
    S_DWT   = 15'b000000010000000,
    S_TGT1  = 15'b000000100000000,
    S_TGT2  = 15'b000001000000000,
    S_TGT3  = 15'b000010000000000,
    S_PICK  = 15'b000100000000000,
    S_UNI   = 15'b001000000000000,
    S_UNI2  = 15'b010000000000000,
    S_UPD   = 15'b100000000000000
  } state_t;

  typedef struct packed {
    logic             start;
    logic [63:0]      num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lgts_if.sv =====
// Token and result stream interfaces of the topic sampler.
`timescale 1ns / 1ps
`default_nettype none
interface lgts_in_if import lgts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [DOC_W-1:0]   doc_index;
  logic [WORD_W-1:0]  word_idx;
  logic [TOPIC_W-1:0] old_topic;
  logic [31:0]        random_value;
  modport source (output valid, mode, doc_index, word_idx, old_topic, random_value,
                  input ready);
  modport sink (input valid, mode, doc_index, word_idx, old_topic, random_value,
                output ready);
endinterface

interface lgts_out_if import lgts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TOPIC_W-1:0] new_topic;
  logic               count_error;
  modport source (output valid, new_topic, count_error, input ready);
  modport sink (input valid, new_topic, count_error, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lgts_div.sv =====
// Restoring divider giving a 32-bit saturated quotient, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module lgts_div import lgts_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  div_req_t  req,
  output div_rsp_t  rsp
);

  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [31:0]      low_r;
  logic [31:0]      quo_r;
  logic [5:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;

  assign trial = {rem_r, low_r[31]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        den_r <= req.den;
        low_r <= req.num[31:0];
        cnt_r <= 6'd32;
        if ({{(DEN_W - 32){1'b0}}, req.num[63:32]} >= req.den) begin
          quo_r  <= '1;
          done_r <= 1'b1;
        end else begin
          rem_r  <= DEN_W'(req.num[63:32]);
          quo_r  <= '0;
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        if (trial >= {1'b0, den_r}) begin
          rem_r <= DEN_W'(trial - {1'b0, den_r});
          quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          rem_r <= trial[DEN_W-1:0];
          quo_r <= {quo_r[30:0], 1'b0};
        end
        low_r <= {low_r[30:0], 1'b0};
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.start) else $error("divider restarted while busy");
  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while still iterating");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != 6'd0) else $error("divider count ran out while busy");

endmodule
`default_nettype wire

// ===== hw/rtl/lda_gibbs_topic_sampler_core.sv =====
// Top level of the LDA collapsed Gibbs topic sampler.
// Tokens arrive as words on in_ch (valid/ready) and each gives one result word on out_ch.
// An assign-mode token draws a topic from random_value and counts it; a resample-mode
// token removes its old topic, weights every active topic, and picks one by the
// running weight sum against random_value, then counts it.
// Priors and the active topic count are to be written over the APB port while idle; the
// user must see to this; the block does not enforce it. One token is worked at a time.
// Per-document and per-word counts are held as rows of all topics in two memories, read
// once and written back once per token. Assign mode passes the read, load and
// uniform-draw states before its result is registered; resample mode works each active
// topic through the shared multiplier and the one-bit-per-cycle divider, then picks by
// scanning the topics in order. The next word can be taken in the cycle after a
// result is registered. An index out of range returns topic 0 with count_error.
// After reset the block sweeps both count memories to zero, one row per cycle, over
// max(DOCS, WORDS) rows (16384 by default); in_ch.ready stays low meanwhile.
// A finished result waits in an output register; the next token is taken while it
// waits, and its result is held back until out_ch takes the earlier one.
`timescale 1ns / 1ps
`default_nettype none
module lda_gibbs_topic_sampler_core import lgts_pkg::*; #(
  parameter int TOPICS     = 16,
  parameter int DOCS       = 16384,
  parameter int WORDS      = 2048,
  parameter int COUNT_BITS = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lgts_in_if.sink     in_ch,
  lgts_out_if.source  out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int TW   = $clog2(TOPICS);
  localparam int KW   = $clog2(TOPICS + 1);
  localparam int SUMW = 32 + KW;
  localparam int DAW  = (DOCS > 1) ? $clog2(DOCS) : 1;
  localparam int WAW  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CLRN = (DOCS > WORDS) ? DOCS : WORDS;
  localparam int CW   = $clog2(CLRN + 1);
  localparam int RW   = TOPICS * COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  typedef logic [TOPICS-1:0][COUNT_BITS-1:0] row_t;

  logic [RW-1:0] dmem [DOCS];
  logic [RW-1:0] wmem [WORDS];
  logic [RW-1:0] drd_r, wrd_r;

  state_t state_r;
  logic [31:0] alpha_r, beta_r, bsum_r;
  logic [4:0]  act_r;
  logic        mode_r;
  logic [DOC_W-1:0]   doc_r;
  logic [WORD_W-1:0]  word_r;
  logic [TOPIC_W-1:0] old_r;
  logic [31:0] rnd_r;
  logic [KW-1:0] k_r;
  logic [TW-1:0] topic_r;
  logic        err_r;
  logic        bad_r;
  logic [SUMW-1:0] total_r, cum_r, tgt_r;
  logic [31:0] tlo_r;
  logic [63:0] prod_r;
  row_t        dr_r, wr_r;
  logic [31:0] tot_r [TOPICS];
  logic [31:0] wt_r [TOPICS];
  logic [CW-1:0] clr_r;
  logic        out_valid_r;
  logic [TOPIC_W-1:0] out_topic_r;
  logic        out_err_r;

  logic [KW-1:0] k_act;
  logic [TW-1:0] kidx;
  logic [31:0] mul_a, mul_b;
  logic [DEN_W-1:0] a_full, b_full, den_full;
  logic [31:0] a_op, b_op;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic in_fire, range_bad, last_k;
  logic [SUMW-1:0] cum_nxt;
  row_t dr_inc, wr_inc;
  logic inc_err;
  logic old_bad, dec_err;
  logic upd_go;
  logic dwe, wwe;
  logic [DAW-1:0] dwa;
  logic [WAW-1:0] wwa;
  logic [RW-1:0] dwd, wwd;

  always_comb begin
    if (act_r == 5'd0) begin
      k_act = KW'(1);
    end else if (32'(act_r) > TOPICS) begin
      k_act = KW'(TOPICS);
    end else begin
      k_act = KW'(act_r);
    end
  end

  assign kidx   = k_r[TW-1:0];
  assign last_k = (k_r == k_act - KW'(1));
  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign range_bad = (32'(in_ch.doc_index) >= DOCS) || (32'(in_ch.word_idx) >= WORDS);
  assign upd_go = (state_r == S_UPD) && (!out_valid_r || out_ch.ready);

  assign a_full = (DEN_W'(dr_r[kidx]) << 16) + DEN_W'(alpha_r);
  assign b_full = (DEN_W'(wr_r[kidx]) << 16) + DEN_W'(beta_r);
  assign a_op = (|a_full[DEN_W-1:32]) ? '1 : a_full[31:0];
  assign b_op = (|b_full[DEN_W-1:32]) ? '1 : b_full[31:0];
  assign den_full = (DEN_W'(tot_r[kidx]) << 16) + DEN_W'(bsum_r);

  always_comb begin
    case (state_r)
      S_MUL: begin
        mul_a = a_op;
        mul_b = b_op;
      end
      S_TGT1: begin
        mul_a = total_r[31:0];
        mul_b = rnd_r;
      end
      S_TGT2: begin
        mul_a = 32'(total_r[SUMW-1:32]);
        mul_b = rnd_r;
      end
      default: begin
        mul_a = 32'(k_act);
        mul_b = rnd_r;
      end
    endcase
  end

  assign div_req.start = (state_r == S_DST);
  assign div_req.num   = prod_r;
  assign div_req.den   = (den_full == '0) ? DEN_W'(1) : den_full;

  lgts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign cum_nxt = cum_r + SUMW'(wt_r[kidx]);

  assign old_bad = (32'(old_r) >= 32'(k_act));

  always_comb begin
    dec_err = old_bad;
    for (int j = 0; j < TOPICS; j++) begin
      if (!old_bad && 32'(j) == 32'(old_r)) begin
        if (dr_r[j] == '0 || wr_r[j] == '0 || tot_r[j] == '0) dec_err = 1'b1;
      end
    end
  end

  always_comb begin
    dr_inc  = dr_r;
    wr_inc  = wr_r;
    inc_err = 1'b0;
    for (int j = 0; j < TOPICS; j++) begin
      if (TW'(j) == topic_r) begin
        if (dr_r[j] == CMAX) inc_err = 1'b1;
        else dr_inc[j] = dr_r[j] + COUNT_BITS'(1);
        if (wr_r[j] == CMAX) inc_err = 1'b1;
        else wr_inc[j] = wr_r[j] + COUNT_BITS'(1);
        if (tot_r[j] == '1) inc_err = 1'b1;
      end
    end
  end

  always_comb begin
    dwe = 1'b0;
    wwe = 1'b0;
    dwa = DAW'(doc_r);
    wwa = WAW'(word_r);
    dwd = dr_inc;
    wwd = wr_inc;
    if (state_r == S_CLEAR) begin
      dwe = (32'(clr_r) < DOCS);
      wwe = (32'(clr_r) < WORDS);
      dwa = DAW'(clr_r);
      wwa = WAW'(clr_r);
      dwd = '0;
      wwd = '0;
    end else if (state_r == S_UPD) begin
      dwe = !bad_r;
      wwe = !bad_r;
    end
  end

  always_ff @(posedge clk) begin
    if (dwe) dmem[dwa] <= dwd;
    if (wwe) wmem[wwa] <= wwd;
    drd_r <= dmem[DAW'(doc_r)];
    wrd_r <= wmem[WAW'(word_r)];
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      alpha_r     <= ALPHA_RST;
      beta_r      <= BETA_RST;
      bsum_r      <= BETA_SUM_RST;
      act_r       <= ACTIVE_RST;
      for (int j = 0; j < TOPICS; j++) tot_r[j] <= '0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          REG_ALPHA:    alpha_r <= pwdata;
          REG_BETA:     beta_r  <= pwdata;
          REG_BETA_SUM: bsum_r  <= pwdata;
          REG_ACTIVE:   act_r   <= pwdata[4:0];
          default:      act_r   <= act_r;
        endcase
      end
      if (upd_go) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;

      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + CW'(1);
          if (32'(clr_r) == CLRN - 1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_fire) begin
            mode_r  <= in_ch.mode;
            doc_r   <= in_ch.doc_index;
            word_r  <= in_ch.word_idx;
            old_r   <= in_ch.old_topic;
            rnd_r   <= in_ch.random_value;
            err_r   <= range_bad;
            bad_r   <= range_bad;
            k_r     <= '0;
            total_r <= '0;
            if (range_bad) begin
              topic_r <= '0;
              state_r <= S_UPD;
            end else begin
              state_r <= S_READ;
            end
          end
        end
        S_READ: state_r <= S_LOAD;
        S_LOAD: begin
          dr_r    <= drd_r;
          wr_r    <= wrd_r;
          state_r <= mode_r ? S_DEC : S_UNI;
        end
        S_DEC: begin
          err_r <= err_r || dec_err;
          if (!old_bad) begin
            for (int j = 0; j < TOPICS; j++) begin
              if (32'(j) == 32'(old_r)) begin
                if (dr_r[j] != '0) dr_r[j] <= dr_r[j] - COUNT_BITS'(1);
                if (wr_r[j] != '0) wr_r[j] <= wr_r[j] - COUNT_BITS'(1);
                if (tot_r[j] != '0) tot_r[j] <= tot_r[j] - 32'd1;
              end
            end
          end
          state_r <= S_MUL;
        end
        S_MUL: state_r <= S_DST;
        S_DST: state_r <= S_DWT;
        S_DWT: begin
          if (div_rsp.done) begin
            wt_r[kidx] <= div_rsp.quo;
            total_r    <= total_r + SUMW'(div_rsp.quo);
            k_r        <= k_r + KW'(1);
            state_r    <= last_k ? S_TGT1 : S_MUL;
          end
        end
        S_TGT1: state_r <= (total_r == '0) ? S_UNI : S_TGT2;
        S_TGT2: begin
          tlo_r   <= prod_r[63:32];
          state_r <= S_TGT3;
        end
        S_TGT3: begin
          tgt_r   <= SUMW'(prod_r) + SUMW'(tlo_r);
          k_r     <= '0;
          cum_r   <= '0;
          state_r <= S_PICK;
        end
        S_PICK: begin
          cum_r <= cum_nxt;
          k_r   <= k_r + KW'(1);
          if ((tgt_r < cum_nxt) || last_k) begin
            topic_r <= kidx;
            state_r <= S_UPD;
          end
        end
        S_UNI: state_r <= S_UNI2;
        S_UNI2: begin
          topic_r <= TW'(prod_r[63:32]);
          state_r <= S_UPD;
        end
        S_UPD: begin
          if (upd_go) begin
            if (!bad_r) begin
              for (int j = 0; j < TOPICS; j++) begin
                if (TW'(j) == topic_r && tot_r[j] != '1) tot_r[j] <= tot_r[j] + 32'd1;
              end
            end
            out_topic_r <= TOPIC_W'(topic_r);
            out_err_r   <= err_r || (!bad_r && inc_err);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.new_topic   = out_topic_r;
  assign out_ch.count_error = out_err_r;

  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      REG_ALPHA:    prdata = alpha_r;
      REG_BETA:     prdata = beta_r;
      REG_BETA_SUM: prdata = bsum_r;
      REG_ACTIVE:   prdata = 32'(act_r);
      default:      prdata = '0;
    endcase
  end

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != S_IDLE) else $error("token taken but sequencer stayed idle");
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DWT) else $error("divider result outside weight step");
  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL || state_r == S_PICK) |-> k_r < k_act)
    else $error("topic index beyond active topics");
  a_no_clear_on_token: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> clr_r == CW'(CLRN)) else $error("token taken before memory sweep ended");

endmodule
`default_nettype wire
